// ===== rtl/hrlp_pkg.sv =====
`timescale 1ns / 1ps

package hrlp_pkg;

	// Line limit and offset field width.
	localparam int MAX_LINE_BYTES = 8192;
	localparam int OFS_W = 13;
	localparam logic [OFS_W-1:0] OFFSET_CAP = OFS_W'(MAX_LINE_BYTES - 1);

	// Characters the parser looks for.
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_P = 8'h50;

	// Packed method letters for the recognized methods.
	localparam logic [31:0] CHARS_GET  = 32'h0047_4554;
	localparam logic [31:0] CHARS_HEAD = 32'h4845_4144;
	localparam logic [31:0] CHARS_POST = 32'h504F_5354;

	typedef enum logic [3:0] {
		P_IDLE      = 4'd0,
		P_METHOD    = 4'd1,
		P_PRE_URI   = 4'd2,
		P_URI       = 4'd3,
		P_PRE_PROTO = 4'd4,
		P_H         = 4'd5,
		P_HT        = 4'd6,
		P_HTT       = 4'd7,
		P_HTTP      = 4'd8,
		P_MAJ_FIRST = 4'd9,
		P_MAJ       = 4'd10,
		P_MIN_FIRST = 4'd11,
		P_MIN       = 4'd12,
		P_TRAIL     = 4'd13,
		P_CR        = 4'd14
	} parse_state_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_METHOD  = 2'd1,
		ST_BAD_REQUEST = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		M_UNKNOWN = 2'd0,
		M_GET     = 2'd1,
		M_HEAD    = 2'd2,
		M_POST    = 2'd3
	} method_t;

	typedef struct packed {
		status_t          status;
		method_t          method_code;
		logic [7:0]       version_major;
		logic [7:0]       version_minor;
		logic [OFS_W-1:0] method_end_offset;
		logic [OFS_W-1:0] uri_start_offset;
		logic [OFS_W-1:0] uri_end_offset;
		logic [OFS_W-1:0] line_end_offset;
	} result_t;

	// What the parse core reports for one byte.
	typedef struct packed {
		logic    done;
		result_t res;
	} core_out_t;

endpackage

// ===== rtl/hrlp_byte_if.sv =====
`timescale 1ns / 1ps

interface hrlp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

// ===== rtl/hrlp_result_if.sv =====
`timescale 1ns / 1ps

interface hrlp_result_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [1:0]                method_code;
	logic [7:0]                version_major;
	logic [7:0]                version_minor;
	logic [hrlp_pkg::OFS_W-1:0] method_end_offset;
	logic [hrlp_pkg::OFS_W-1:0] uri_start_offset;
	logic [hrlp_pkg::OFS_W-1:0] uri_end_offset;
	logic [hrlp_pkg::OFS_W-1:0] line_end_offset;

	modport source(output valid, output status, output method_code, output version_major,
		output version_minor, output method_end_offset, output uri_start_offset,
		output uri_end_offset, output line_end_offset, input ready);
	modport sink(input valid, input status, input method_code, input version_major,
		input version_minor, input method_end_offset, input uri_start_offset,
		input uri_end_offset, input line_end_offset, output ready);
endinterface

// ===== rtl/hrlp_core.sv =====
`timescale 1ns / 1ps

module hrlp_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	output hrlp_pkg::core_out_t    core_out
);

	// Per-line state.
	hrlp_pkg::parse_state_t      state_q, state_d;
	logic [hrlp_pkg::OFS_W-1:0]  offset_q;
	logic [31:0]                 chars_q;
	logic [2:0]                  len_q;
	hrlp_pkg::method_t           kind_q;
	logic [7:0]                  major_q;
	logic [7:0]                  minor_q;
	logic [hrlp_pkg::OFS_W-1:0]  method_end_q;
	logic [hrlp_pkg::OFS_W-1:0]  uri_start_q;
	logic [hrlp_pkg::OFS_W-1:0]  uri_end_q;
	logic [hrlp_pkg::OFS_W-1:0]  line_end_q;
	logic                        line_end_seen_q;

	// Decoded events for the current byte.
	logic                        done;
	hrlp_pkg::status_t           status;
	logic                        skip;
	logic                        first_char;
	logic                        add_char;
	logic                        set_method_end;
	logic                        set_uri_start;
	logic                        set_uri_end;
	logic                        set_line_end;
	logic                        load_major;
	logic                        acc_major;
	logic                        load_minor;
	logic                        acc_minor;

	logic [hrlp_pkg::OFS_W-1:0]  cur;
	logic                        is_method_char;
	logic                        is_digit;
	hrlp_pkg::method_t           kind_new;
	logic [7:0]                  major_next;
	logic [7:0]                  minor_next;

	// Decimal accumulate with saturation at 255.
	function automatic logic [7:0] dec_acc(input logic [7:0] acc, input logic [7:0] b);
		logic [11:0] v;
		v = 12'(acc) * 12'd10 + 12'(b[3:0]);
		return (v > 12'd255) ? 8'hFF : v[7:0];
	endfunction

	assign cur = (state_q == hrlp_pkg::P_IDLE) ? '0 : offset_q;
	assign is_method_char = (data_byte >= hrlp_pkg::CH_UPPER_A && data_byte <= hrlp_pkg::CH_UPPER_Z)
		|| data_byte == hrlp_pkg::CH_UNDERSCORE;
	assign is_digit = data_byte >= hrlp_pkg::CH_ZERO && data_byte <= hrlp_pkg::CH_NINE;
	assign major_next = dec_acc(major_q, data_byte);
	assign minor_next = dec_acc(minor_q, data_byte);

	// Method classification from the letters collected so far.
	always_comb begin
		if (len_q == 3'd3 && chars_q == hrlp_pkg::CHARS_GET) begin
			kind_new = hrlp_pkg::M_GET;
		end else if (len_q == 3'd4 && chars_q == hrlp_pkg::CHARS_HEAD) begin
			kind_new = hrlp_pkg::M_HEAD;
		end else if (len_q == 3'd4 && chars_q == hrlp_pkg::CHARS_POST) begin
			kind_new = hrlp_pkg::M_POST;
		end else begin
			kind_new = hrlp_pkg::M_UNKNOWN;
		end
	end

	// Next state and per-byte events.
	always_comb begin
		state_d        = state_q;
		done           = 1'b0;
		status         = hrlp_pkg::ST_OK;
		skip           = 1'b0;
		first_char     = 1'b0;
		add_char       = 1'b0;
		set_method_end = 1'b0;
		set_uri_start  = 1'b0;
		set_uri_end    = 1'b0;
		set_line_end   = 1'b0;
		load_major     = 1'b0;
		acc_major      = 1'b0;
		load_minor     = 1'b0;
		acc_minor      = 1'b0;
		case (state_q)
			hrlp_pkg::P_METHOD: begin
				if (data_byte == hrlp_pkg::CH_SPACE) begin
					set_method_end = 1'b1;
					state_d = hrlp_pkg::P_PRE_URI;
				end else if (is_method_char) begin
					add_char = 1'b1;
				end else begin
					done = 1'b1;
					status = hrlp_pkg::ST_BAD_METHOD;
				end
			end
			hrlp_pkg::P_PRE_URI: begin
				if (data_byte == hrlp_pkg::CH_SLASH) begin
					set_uri_start = 1'b1;
					state_d = hrlp_pkg::P_URI;
				end else if (data_byte != hrlp_pkg::CH_SPACE) begin
					done = 1'b1;
					status = hrlp_pkg::ST_BAD_REQUEST;
				end
			end
			hrlp_pkg::P_URI: begin
				if (data_byte == hrlp_pkg::CH_SPACE) begin
					set_uri_end = 1'b1;
					state_d = hrlp_pkg::P_PRE_PROTO;
				end
			end
			hrlp_pkg::P_PRE_PROTO: begin
				if (data_byte == hrlp_pkg::CH_H) begin
					state_d = hrlp_pkg::P_H;
				end else if (data_byte != hrlp_pkg::CH_SPACE) begin
					done = 1'b1;
					status = hrlp_pkg::ST_BAD_REQUEST;
				end
			end
			hrlp_pkg::P_H, hrlp_pkg::P_HT, hrlp_pkg::P_HTT, hrlp_pkg::P_HTTP: begin
				// Fixed protocol name, one letter a byte.
				if (state_q == hrlp_pkg::P_H && data_byte == hrlp_pkg::CH_T) begin
					state_d = hrlp_pkg::P_HT;
				end else if (state_q == hrlp_pkg::P_HT && data_byte == hrlp_pkg::CH_T) begin
					state_d = hrlp_pkg::P_HTT;
				end else if (state_q == hrlp_pkg::P_HTT && data_byte == hrlp_pkg::CH_P) begin
					state_d = hrlp_pkg::P_HTTP;
				end else if (state_q == hrlp_pkg::P_HTTP
					&& data_byte == hrlp_pkg::CH_SLASH) begin
					state_d = hrlp_pkg::P_MAJ_FIRST;
				end else begin
					done = 1'b1;
					status = hrlp_pkg::ST_BAD_REQUEST;
				end
			end
			hrlp_pkg::P_MAJ_FIRST: begin
				if (data_byte >= hrlp_pkg::CH_ONE && data_byte <= hrlp_pkg::CH_NINE) begin
					load_major = 1'b1;
					state_d = hrlp_pkg::P_MAJ;
				end else begin
					done = 1'b1;
					status = hrlp_pkg::ST_BAD_REQUEST;
				end
			end
			hrlp_pkg::P_MAJ: begin
				if (data_byte == hrlp_pkg::CH_DOT) begin
					state_d = hrlp_pkg::P_MIN_FIRST;
				end else if (is_digit) begin
					acc_major = 1'b1;
				end else begin
					done = 1'b1;
					status = hrlp_pkg::ST_BAD_REQUEST;
				end
			end
			hrlp_pkg::P_MIN_FIRST: begin
				if (is_digit) begin
					load_minor = 1'b1;
					state_d = hrlp_pkg::P_MIN;
				end else begin
					done = 1'b1;
					status = hrlp_pkg::ST_BAD_REQUEST;
				end
			end
			hrlp_pkg::P_MIN, hrlp_pkg::P_TRAIL: begin
				if (data_byte == hrlp_pkg::CH_CR) begin
					set_line_end = 1'b1;
					state_d = hrlp_pkg::P_CR;
				end else if (data_byte == hrlp_pkg::CH_LF) begin
					done = 1'b1;
				end else if (data_byte == hrlp_pkg::CH_SPACE) begin
					state_d = hrlp_pkg::P_TRAIL;
				end else if (state_q == hrlp_pkg::P_MIN && is_digit) begin
					acc_minor = 1'b1;
				end else begin
					done = 1'b1;
					status = hrlp_pkg::ST_BAD_REQUEST;
				end
			end
			hrlp_pkg::P_CR: begin
				done = 1'b1;
				if (data_byte != hrlp_pkg::CH_LF) begin
					status = hrlp_pkg::ST_BAD_REQUEST;
				end
			end
			default: begin
				// Start of line; unused codes behave the same.
				state_d = hrlp_pkg::P_IDLE;
				if (data_byte == hrlp_pkg::CH_CR || data_byte == hrlp_pkg::CH_LF) begin
					skip = 1'b1;
				end else if (!is_method_char) begin
					done = 1'b1;
					status = hrlp_pkg::ST_BAD_METHOD;
				end else begin
					first_char = 1'b1;
					state_d = hrlp_pkg::P_METHOD;
				end
			end
		endcase
	end

	// Result fields: all zero for an error.
	always_comb begin
		core_out.done = done;
		core_out.res = '0;
		core_out.res.status = status;
		if (status == hrlp_pkg::ST_OK) begin
			core_out.res.method_code       = kind_q;
			core_out.res.version_major     = major_q;
			core_out.res.version_minor     = minor_q;
			core_out.res.method_end_offset = method_end_q;
			core_out.res.uri_start_offset  = uri_start_q;
			core_out.res.uri_end_offset    = uri_end_q;
			core_out.res.line_end_offset   = line_end_seen_q ? line_end_q : cur;
		end
	end

	// State update for each byte; a finished line clears everything.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= hrlp_pkg::P_IDLE;
			offset_q        <= '0;
			chars_q         <= '0;
			len_q           <= '0;
			kind_q          <= hrlp_pkg::M_UNKNOWN;
			major_q         <= '0;
			minor_q         <= '0;
			method_end_q    <= '0;
			uri_start_q     <= '0;
			uri_end_q       <= '0;
			line_end_q      <= '0;
			line_end_seen_q <= 1'b0;
		end else if (step) begin
			if (done) begin
				state_q         <= hrlp_pkg::P_IDLE;
				offset_q        <= '0;
				chars_q         <= '0;
				len_q           <= '0;
				kind_q          <= hrlp_pkg::M_UNKNOWN;
				major_q         <= '0;
				minor_q         <= '0;
				method_end_q    <= '0;
				uri_start_q     <= '0;
				uri_end_q       <= '0;
				line_end_q      <= '0;
				line_end_seen_q <= 1'b0;
			end else begin
				state_q <= state_d;
				if (!skip) begin
					offset_q <= (cur < hrlp_pkg::OFFSET_CAP) ? cur + 1'b1 : hrlp_pkg::OFFSET_CAP;
				end
				if (first_char) begin
					chars_q <= {24'h0, data_byte};
					len_q   <= 3'd1;
				end else if (add_char) begin
					if (len_q < 3'd4) begin
						chars_q <= {chars_q[23:0], data_byte};
					end
					if (len_q < 3'd7) begin
						len_q <= len_q + 3'd1;
					end
				end
				if (set_method_end) begin
					method_end_q <= cur;
					kind_q       <= kind_new;
				end
				if (set_uri_start) begin
					uri_start_q <= cur;
				end
				if (set_uri_end) begin
					uri_end_q <= cur;
				end
				if (set_line_end) begin
					line_end_q      <= cur;
					line_end_seen_q <= 1'b1;
				end
				if (load_major) begin
					major_q <= {4'h0, data_byte[3:0]};
				end else if (acc_major) begin
					major_q <= major_next;
				end
				if (load_minor) begin
					minor_q <= {4'h0, data_byte[3:0]};
				end else if (acc_minor) begin
					minor_q <= minor_next;
				end
			end
		end
	end

endmodule

// ===== rtl/http_request_line_parser_top.sv =====
`timescale 1ns / 1ps

// Channel | Role | Payload
// stream  | sink   | data_byte: one byte of the request line
// result  | source | status, method_code, version_major/minor, four offsets
//
// One byte is taken every cycle unless an untaken result holds it back. The byte that ends
// the line or shows the error goes through the input register, the combinational parse step
// and the result register, which then offers the result. Reset clears the parse state to the
// start of a line. While a result waits untaken, the byte in the input register holds and
// the stream takes no new request once that register is full.

module http_request_line_parser_top (
	input  logic                 clk,
	input  logic                 arst_n,
	hrlp_byte_if.sink            stream,
	hrlp_result_if.source        result
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 advance;
	hrlp_pkg::core_out_t  core_out;
	logic                 res_valid_q;
	hrlp_pkg::result_t    res_q;

	// The input stage moves on when the result register can take what it makes.
	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.data_byte;
		end
	end

	hrlp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.core_out  (core_out)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && core_out.done) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_out.done) begin
			res_q <= core_out.res;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.status            = res_q.status;
	assign result.method_code       = res_q.method_code;
	assign result.version_major     = res_q.version_major;
	assign result.version_minor     = res_q.version_minor;
	assign result.method_end_offset = res_q.method_end_offset;
	assign result.uri_start_offset  = res_q.uri_start_offset;
	assign result.uri_end_offset    = res_q.uri_end_offset;
	assign result.line_end_offset   = res_q.line_end_offset;

endmodule

// ===== rtl/hrlp_checker.sv =====
`timescale 1ns / 1ps

module hrlp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [1:0]                 status,
	input logic [1:0]                 method_code,
	input logic [7:0]                 version_major,
	input logic [7:0]                 version_minor,
	input logic [hrlp_pkg::OFS_W-1:0] method_end_offset,
	input logic [hrlp_pkg::OFS_W-1:0] uri_start_offset,
	input logic [hrlp_pkg::OFS_W-1:0] uri_end_offset,
	input logic [hrlp_pkg::OFS_W-1:0] line_end_offset
);

	// A result that is not taken stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before it was taken");

	// A stalled result keeps its fields.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({status, method_code, version_major,
			version_minor, method_end_offset, uri_start_offset, uri_end_offset,
			line_end_offset}))
		else $error("stalled result changed");

	// An error result carries nothing but its status.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != hrlp_pkg::ST_OK |->
			method_code == '0 && version_major == '0 && version_minor == '0
			&& method_end_offset == '0 && uri_start_offset == '0
			&& uri_end_offset == '0 && line_end_offset == '0)
		else $error("error result with nonzero fields");

	// A complete line has its landmarks in order and a major version of at least one.
	a_ok_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == hrlp_pkg::ST_OK |->
			method_end_offset <= uri_start_offset && uri_start_offset <= uri_end_offset
			&& uri_end_offset <= line_end_offset && version_major != 8'd0)
		else $error("complete line with offsets out of order");

endmodule

bind http_request_line_parser_top hrlp_checker u_hrlp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (result.valid),
	.res_ready         (result.ready),
	.status            (result.status),
	.method_code       (result.method_code),
	.version_major     (result.version_major),
	.version_minor     (result.version_minor),
	.method_end_offset (result.method_end_offset),
	.uri_start_offset  (result.uri_start_offset),
	.uri_end_offset    (result.uri_end_offset),
	.line_end_offset   (result.line_end_offset)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	// Predicts the parser result for each accepted byte and checks what comes out.
	class line_result_book;
		hrlp_pkg::result_t expected_lines[$];
		int mismatches;
		int parsed_bytes;
		int results_seen;
		int n_ok;
		int n_bad_method;
		int n_bad_request;
		int n_by_method[4];

		// Parser state, one copy per line.
		hrlp_pkg::parse_state_t state;
		logic [hrlp_pkg::OFS_W-1:0] offset;
		logic [hrlp_pkg::OFS_W-1:0] method_stop;
		logic [hrlp_pkg::OFS_W-1:0] target_first;
		logic [hrlp_pkg::OFS_W-1:0] uri_end;
		logic [hrlp_pkg::OFS_W-1:0] line_end;
		logic [31:0] letters;
		int unsigned letter_count;
		hrlp_pkg::method_t method_kind;
		logic [7:0] major;
		logic [7:0] minor;
		bit cr_seen;

		function new();
			clear_line();
		endfunction

		function void clear_line();
			state = hrlp_pkg::P_IDLE;
			offset = '0;
			method_stop = '0;
			target_first = '0;
			uri_end = '0;
			line_end = '0;
			letters = '0;
			letter_count = 0;
			method_kind = hrlp_pkg::M_UNKNOWN;
			major = '0;
			minor = '0;
			cr_seen = 1'b0;
		endfunction

		function bit is_method_letter(logic [7:0] b);
			return (b >= hrlp_pkg::CH_UPPER_A && b <= hrlp_pkg::CH_UPPER_Z)
				|| b == hrlp_pkg::CH_UNDERSCORE;
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= hrlp_pkg::CH_ZERO && b <= hrlp_pkg::CH_NINE;
		endfunction

		function logic [7:0] decimal_step(logic [7:0] acc, logic [7:0] b);
			int v;
			v = int'(acc) * 10 + int'(b - hrlp_pkg::CH_ZERO);
			return (v > 255) ? 8'd255 : 8'(v);
		endfunction

		// Only the first four letters are kept; the length stops counting at seven.
		function void push_letter(logic [7:0] b);
			if (letter_count < 4) begin
				letters = {letters[23:0], b};
			end
			if (letter_count < 7) begin
				letter_count++;
			end
		endfunction

		// Advances the parser by one accepted byte and queues any result it ends in.
		function void take_byte(logic [7:0] b);
			logic [hrlp_pkg::OFS_W-1:0] cur;
			bit done;
			hrlp_pkg::status_t verdict;
			hrlp_pkg::result_t r;
			// Line breaks before a method are dropped without moving the offset.
			if (state == hrlp_pkg::P_IDLE && (b == hrlp_pkg::CH_CR || b == hrlp_pkg::CH_LF)) begin
				return;
			end
			parsed_bytes++;
			cur = (state == hrlp_pkg::P_IDLE) ? '0 : offset;
			done = 1'b0;
			verdict = hrlp_pkg::ST_OK;
			case (state)
				hrlp_pkg::P_METHOD: begin
					if (b == hrlp_pkg::CH_SPACE) begin
						method_stop = cur;
						method_kind = hrlp_pkg::M_UNKNOWN;
						if (letter_count == 3 && letters == hrlp_pkg::CHARS_GET) begin
							method_kind = hrlp_pkg::M_GET;
						end else if (letter_count == 4 && letters == hrlp_pkg::CHARS_HEAD) begin
							method_kind = hrlp_pkg::M_HEAD;
						end else if (letter_count == 4 && letters == hrlp_pkg::CHARS_POST) begin
							method_kind = hrlp_pkg::M_POST;
						end
						state = hrlp_pkg::P_PRE_URI;
					end else if (is_method_letter(b)) begin
						push_letter(b);
					end else begin
						done = 1'b1;
						verdict = hrlp_pkg::ST_BAD_METHOD;
					end
				end
				hrlp_pkg::P_PRE_URI: begin
					if (b == hrlp_pkg::CH_SLASH) begin
						target_first = cur;
						state = hrlp_pkg::P_URI;
					end else if (b != hrlp_pkg::CH_SPACE) begin
						done = 1'b1;
						verdict = hrlp_pkg::ST_BAD_REQUEST;
					end
				end
				hrlp_pkg::P_URI: begin
					if (b == hrlp_pkg::CH_SPACE) begin
						uri_end = cur;
						state = hrlp_pkg::P_PRE_PROTO;
					end
				end
				hrlp_pkg::P_PRE_PROTO: begin
					if (b == hrlp_pkg::CH_H) begin
						state = hrlp_pkg::P_H;
					end else if (b != hrlp_pkg::CH_SPACE) begin
						done = 1'b1;
						verdict = hrlp_pkg::ST_BAD_REQUEST;
					end
				end
				hrlp_pkg::P_H, hrlp_pkg::P_HT, hrlp_pkg::P_HTT, hrlp_pkg::P_HTTP: begin
					if (state == hrlp_pkg::P_H && b == hrlp_pkg::CH_T) begin
						state = hrlp_pkg::P_HT;
					end else if (state == hrlp_pkg::P_HT && b == hrlp_pkg::CH_T) begin
						state = hrlp_pkg::P_HTT;
					end else if (state == hrlp_pkg::P_HTT && b == hrlp_pkg::CH_P) begin
						state = hrlp_pkg::P_HTTP;
					end else if (state == hrlp_pkg::P_HTTP && b == hrlp_pkg::CH_SLASH) begin
						state = hrlp_pkg::P_MAJ_FIRST;
					end else begin
						done = 1'b1;
						verdict = hrlp_pkg::ST_BAD_REQUEST;
					end
				end
				hrlp_pkg::P_MAJ_FIRST: begin
					if (b >= hrlp_pkg::CH_ONE && b <= hrlp_pkg::CH_NINE) begin
						major = b - hrlp_pkg::CH_ZERO;
						state = hrlp_pkg::P_MAJ;
					end else begin
						done = 1'b1;
						verdict = hrlp_pkg::ST_BAD_REQUEST;
					end
				end
				hrlp_pkg::P_MAJ: begin
					if (b == hrlp_pkg::CH_DOT) begin
						state = hrlp_pkg::P_MIN_FIRST;
					end else if (is_digit(b)) begin
						major = decimal_step(major, b);
					end else begin
						done = 1'b1;
						verdict = hrlp_pkg::ST_BAD_REQUEST;
					end
				end
				hrlp_pkg::P_MIN_FIRST: begin
					if (is_digit(b)) begin
						minor = b - hrlp_pkg::CH_ZERO;
						state = hrlp_pkg::P_MIN;
					end else begin
						done = 1'b1;
						verdict = hrlp_pkg::ST_BAD_REQUEST;
					end
				end
				hrlp_pkg::P_MIN, hrlp_pkg::P_TRAIL: begin
					if (b == hrlp_pkg::CH_CR) begin
						line_end = cur;
						cr_seen = 1'b1;
						state = hrlp_pkg::P_CR;
					end else if (b == hrlp_pkg::CH_LF) begin
						done = 1'b1;
					end else if (b == hrlp_pkg::CH_SPACE) begin
						state = hrlp_pkg::P_TRAIL;
					end else if (state == hrlp_pkg::P_MIN && is_digit(b)) begin
						minor = decimal_step(minor, b);
					end else begin
						done = 1'b1;
						verdict = hrlp_pkg::ST_BAD_REQUEST;
					end
				end
				hrlp_pkg::P_CR: begin
					done = 1'b1;
					verdict = (b == hrlp_pkg::CH_LF) ? hrlp_pkg::ST_OK : hrlp_pkg::ST_BAD_REQUEST;
				end
				default: begin
					if (is_method_letter(b)) begin
						letters = '0;
						letter_count = 0;
						push_letter(b);
						state = hrlp_pkg::P_METHOD;
					end else begin
						done = 1'b1;
						verdict = hrlp_pkg::ST_BAD_METHOD;
					end
				end
			endcase

			// The offset saturates at the line limit.
			if (!done) begin
				offset = (cur < hrlp_pkg::OFFSET_CAP) ? cur + 1'b1 : hrlp_pkg::OFFSET_CAP;
				return;
			end

			// Errors carry only the status; every other field is zero.
			r = '0;
			r.status = verdict;
			if (verdict == hrlp_pkg::ST_OK) begin
				r.method_code = method_kind;
				r.version_major = major;
				r.version_minor = minor;
				r.method_end_offset = method_stop;
				r.uri_start_offset = target_first;
				r.uri_end_offset = uri_end;
				r.line_end_offset = cr_seen ? line_end : cur;
			end
			expected_lines.push_back(r);
			clear_line();
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 30) begin
				$display("MISMATCH at %0t: %s", $realtime, msg);
			end
		endtask

		task check_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want) begin
				report($sformatf("result %0d %s got %0d expected %0d", results_seen, name,
					got, want));
			end
		endtask

		// Compares one taken result with the oldest predicted line.
		task check_result(hrlp_pkg::result_t got);
			hrlp_pkg::result_t want;
			if (expected_lines.size() == 0) begin
				report($sformatf("result with no line pending, status %0d", got.status));
				return;
			end
			want = expected_lines.pop_front();
			results_seen++;
			case (want.status)
				hrlp_pkg::ST_OK: begin
					n_ok++;
					n_by_method[want.method_code]++;
				end
				hrlp_pkg::ST_BAD_METHOD: n_bad_method++;
				default: n_bad_request++;
			endcase
			check_field("status", got.status, want.status);
			check_field("method_code", got.method_code, want.method_code);
			check_field("version_major", got.version_major, want.version_major);
			check_field("version_minor", got.version_minor, want.version_minor);
			check_field("method_end_offset", got.method_end_offset, want.method_end_offset);
			check_field("uri_start_offset", got.uri_start_offset, want.uri_start_offset);
			check_field("uri_end_offset", got.uri_end_offset, want.uri_end_offset);
			check_field("line_end_offset", got.line_end_offset, want.line_end_offset);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit calm = 1'b0;
	line_result_book book = new();

	hrlp_byte_if stream();
	hrlp_result_if result();

	http_request_line_parser_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.result(result)
	);

	always #2 clk = ~clk;

	// Offers one byte after a random gap and waits until the request is taken.
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			stream.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream.valid <= 1'b1;
		stream.data_byte <= b;
		do begin
			@(negedge clk);
		end while (stream.ready !== 1'b1);
		@(posedge clk);
		book.take_byte(b);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	task automatic send_request(string s, bit with_cr);
		send_text(s);
		if (with_cr) begin
			send_byte(hrlp_pkg::CH_CR);
		end
		send_byte(hrlp_pkg::CH_LF);
	endtask

	function automatic void put_text(ref logic [7:0] q[$], input string s);
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
	endfunction

	// Holds the stream idle until every predicted result has been taken.
	task automatic wait_for_results();
		stream.valid <= 1'b0;
		@(posedge clk);
		while (book.expected_lines.size() != 0) @(posedge clk);
	endtask

	// Result side: stalls at random, then takes one result and checks it.
	initial begin
		int stall;
		hrlp_pkg::result_t got;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do begin
				@(negedge clk);
			end while (result.valid !== 1'b1);
			got.status = hrlp_pkg::status_t'(result.status);
			got.method_code = hrlp_pkg::method_t'(result.method_code);
			got.version_major = result.version_major;
			got.version_minor = result.version_minor;
			got.method_end_offset = result.method_end_offset;
			got.uri_start_offset = result.uri_start_offset;
			got.uri_end_offset = result.uri_end_offset;
			got.line_end_offset = result.line_end_offset;
			@(posedge clk);
			book.check_result(got);
		end
	end

	// Stream side: directed lines, then random lines with some noise and damage.
	initial begin
		logic [7:0] q[$];
		int n;
		stream.valid <= 1'b0;
		stream.data_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Well-formed lines: leading line breaks, each method, CR in the URI, trailing spaces.
		send_byte(hrlp_pkg::CH_CR);
		send_byte(hrlp_pkg::CH_LF);
		send_request("GET / HTTP/1.1", 1'b1);
		send_request("HEAD /index.html HTTP/1.0", 1'b0);
		send_text("POST  /a");
		send_byte(hrlp_pkg::CH_CR);
		send_byte(hrlp_pkg::CH_LF);
		send_request("b HTTP/2.0  ", 1'b1);

		// Methods that are not recognized, and a method longer than seven letters.
		send_request("PUT /x HTTP/1.1", 1'b1);
		send_request("HEAX /y HTTP/1.1", 1'b0);
		send_request("A_B_CDEFGHIJ /z HTTP/9.9", 1'b0);

		// Version numbers that saturate.
		send_request("GET / HTTP/999.300", 1'b1);

		// Bad first bytes and a method broken by a line break.
		send_text("g");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(hrlp_pkg::CH_SPACE);
		send_text("GET");
		send_byte(hrlp_pkg::CH_CR);

		// Lines malformed after the method, each failing at a different point.
		send_text("GET x");
		send_text("GET /  X");
		send_text("GET / HTX");
		send_text("GET / HTTP/0");
		send_text("GET / HTTP/1.x");
		send_request("GET / HTTP/1", 1'b0);
		send_text("GET / HTTP/1.1 5");
		send_text("GET / HTTP/1.1");
		send_byte(hrlp_pkg::CH_CR);
		send_text("X");

		wait_for_results();

		// Random lines: mostly well formed, some pure noise, some damaged.
		while (book.parsed_bytes < 1750) begin
			calm = ($urandom_range(0, 7) == 0);
			q.delete();
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
					q.push_back($urandom_range(0, 1) ? hrlp_pkg::CH_CR : hrlp_pkg::CH_LF);
				end
				case ($urandom_range(0, 5))
					0: put_text(q, "GET");
					1: put_text(q, "HEAD");
					2: put_text(q, "POST");
					3: begin
						put_text(q, "GE");
						n = $urandom_range(0, 26);
						q.push_back(n == 26 ? hrlp_pkg::CH_UNDERSCORE
							: 8'(hrlp_pkg::CH_UPPER_A + n));
					end
					4: begin
						if ($urandom_range(0, 1)) begin
							put_text(q, "HEA");
						end else begin
							put_text(q, "POS");
						end
						n = $urandom_range(0, 26);
						q.push_back(n == 26 ? hrlp_pkg::CH_UNDERSCORE
							: 8'(hrlp_pkg::CH_UPPER_A + n));
					end
					default: begin
						repeat ($urandom_range(1, 9)) begin
							n = $urandom_range(0, 26);
							q.push_back(n == 26 ? hrlp_pkg::CH_UNDERSCORE
								: 8'(hrlp_pkg::CH_UPPER_A + n));
						end
					end
				endcase
				repeat ($urandom_range(1, 2)) q.push_back(hrlp_pkg::CH_SPACE);
				q.push_back(hrlp_pkg::CH_SLASH);
				repeat ($urandom_range(0, 10)) begin
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
						$urandom_range(8'h21, 8'h7E);
					q.push_back(n == hrlp_pkg::CH_SPACE ? hrlp_pkg::CH_CR : 8'(n));
				end
				repeat ($urandom_range(1, 2)) q.push_back(hrlp_pkg::CH_SPACE);
				put_text(q, "HTTP/");
				q.push_back(8'(hrlp_pkg::CH_ZERO + $urandom_range(1, 9)));
				repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0) begin
					q.push_back(8'(hrlp_pkg::CH_ZERO + $urandom_range(0, 9)));
				end
				q.push_back(hrlp_pkg::CH_DOT);
				repeat ($urandom_range(0, 4) == 0 ? $urandom_range(2, 4) : 1) begin
					q.push_back(8'(hrlp_pkg::CH_ZERO + $urandom_range(0, 9)));
				end
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
					q.push_back(hrlp_pkg::CH_SPACE);
				end
				if ($urandom_range(0, 1)) begin
					q.push_back(hrlp_pkg::CH_CR);
				end
				q.push_back(hrlp_pkg::CH_LF);

				// Damage a quarter of the lines: one byte replaced, or the line cut short.
				case ($urandom_range(0, 7))
					0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
					1: q = q[0:$urandom_range(0, q.size() - 1)];
					default: begin
					end
				endcase
			end
			foreach (q[i]) begin
				send_byte(q[i]);
			end
			if ($urandom_range(0, 39) == 0) begin
				wait_for_results();
			end
		end

		// Let the last results drain, then watch for stray ones.
		calm = 1'b0;
		wait_for_results();
		repeat (8) @(posedge clk);

		$display("Parsed %0d bytes into %0d results: %0d complete, %0d bad method, %0d bad request.",
			book.parsed_bytes, book.results_seen, book.n_ok, book.n_bad_method,
			book.n_bad_request);
		$display("Complete lines by method: unknown %0d, GET %0d, HEAD %0d, POST %0d.",
			book.n_by_method[hrlp_pkg::M_UNKNOWN], book.n_by_method[hrlp_pkg::M_GET],
			book.n_by_method[hrlp_pkg::M_HEAD], book.n_by_method[hrlp_pkg::M_POST]);
		if (book.mismatches == 0 && book.expected_lines.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
